// ----- design/biquad_pkg.sv -----
// shared constants for the second-order iir filter
package biquad_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_BITS_DEF      = 32;
    localparam int COEF_FRAC_BITS_DEF = 30;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FB_COEF_ONE  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FB_COEF_TWO  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FF_COEF_ZERO = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FF_COEF_ONE  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FF_COEF_TWO  = 3'd4;

endpackage

// ----- design/second_order_iir_filter.sv -----
// top level of the direct form i biquad filter
// One sample in, one sample out. y = a1*y1 + a2*y2 + b0*u + b1*u1 + b2*u2 with
// Q(COEF_BITS-COEF_FRAC_BITS).COEF_FRAC_BITS coefficients, rounded to nearest (ties
// toward plus infinity) and saturated to SAMPLE_BITS; the saturated value is fed
// back. Accepted samples pass the input stage, then the output register; one sample
// can be taken every cycle while m_ is not stalled. The cycle is set by the feedback
// path: two coefficient multiplies, the five-term sum, rounding and saturation
// between the input stage and the output register. Coefficients and history reset
// to zero; write the coefficients through the cfg_ channel (index 0 a1, 1 a2, 2 b0,
// 3 b1, 4 b2, other indexes ignored) only while no sample is in flight.
module second_order_iir_filter
    import biquad_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_BITS      = COEF_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int TDATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [TDATA_BITS-1:0]     s_tdata,    // sample_in
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [TDATA_BITS-1:0]     m_tdata,    // sample_out
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data
);

    logic signed [COEF_BITS-1:0]   fb_coef_one_reg;
    logic signed [COEF_BITS-1:0]   fb_coef_two_reg;
    logic signed [COEF_BITS-1:0]   ff_coef_zero_reg;
    logic signed [COEF_BITS-1:0]   ff_coef_one_reg;
    logic signed [COEF_BITS-1:0]   ff_coef_two_reg;

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;

    logic signed [SAMPLE_BITS-1:0] input_delay_one_reg;
    logic signed [SAMPLE_BITS-1:0] input_delay_two_reg;
    logic signed [SAMPLE_BITS-1:0] output_delay_one_reg;
    logic signed [SAMPLE_BITS-1:0] output_delay_two_reg;

    logic signed [SAMPLE_BITS-1:0] result;
    logic                          advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = TDATA_BITS'($unsigned(out_sample_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_coef_one_reg  <= '0;
            fb_coef_two_reg  <= '0;
            ff_coef_zero_reg <= '0;
            ff_coef_one_reg  <= '0;
            ff_coef_two_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FB_COEF_ONE:  fb_coef_one_reg  <= cfg_data;
                REG_FB_COEF_TWO:  fb_coef_two_reg  <= cfg_data;
                REG_FF_COEF_ZERO: ff_coef_zero_reg <= cfg_data;
                REG_FF_COEF_ONE:  ff_coef_one_reg  <= cfg_data;
                REG_FF_COEF_TWO:  ff_coef_two_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (advance) begin
            out_sample_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_delay_one_reg  <= '0;
            input_delay_two_reg  <= '0;
            output_delay_one_reg <= '0;
            output_delay_two_reg <= '0;
        end else if (advance) begin
            input_delay_one_reg  <= in_sample_reg;
            input_delay_two_reg  <= input_delay_one_reg;
            output_delay_one_reg <= result;
            output_delay_two_reg <= output_delay_one_reg;
        end
    end

    biquad_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_BITS      (COEF_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .fb_coef_one      (fb_coef_one_reg),
        .fb_coef_two      (fb_coef_two_reg),
        .ff_coef_zero     (ff_coef_zero_reg),
        .ff_coef_one      (ff_coef_one_reg),
        .ff_coef_two      (ff_coef_two_reg),
        .sample           (in_sample_reg),
        .input_delay_one  (input_delay_one_reg),
        .input_delay_two  (input_delay_two_reg),
        .output_delay_one (output_delay_one_reg),
        .output_delay_two (output_delay_two_reg),
        .result           (result)
    );

endmodule

// ----- design/biquad_mac.sv -----
// five-term multiply-accumulate with rounding and saturation
module biquad_mac
    import biquad_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_BITS      = COEF_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic signed [COEF_BITS-1:0]   fb_coef_one,
    input  logic signed [COEF_BITS-1:0]   fb_coef_two,
    input  logic signed [COEF_BITS-1:0]   ff_coef_zero,
    input  logic signed [COEF_BITS-1:0]   ff_coef_one,
    input  logic signed [COEF_BITS-1:0]   ff_coef_two,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] input_delay_one,
    input  logic signed [SAMPLE_BITS-1:0] input_delay_two,
    input  logic signed [SAMPLE_BITS-1:0] output_delay_one,
    input  logic signed [SAMPLE_BITS-1:0] output_delay_two,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = (PROD_BITS + 3 > COEF_FRAC_BITS + SAMPLE_BITS + 2)
                             ? PROD_BITS + 3 : COEF_FRAC_BITS + SAMPLE_BITS + 2;
    localparam int SH_BITS   = ACC_BITS - COEF_FRAC_BITS;

    localparam logic signed [ACC_BITS-1:0] HALF_LSB =
        ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SH_BITS-1:0] SAT_MAX =
        SH_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SH_BITS-1:0] SAT_MIN = -SAT_MAX - SH_BITS'(1);

    logic signed [PROD_BITS-1:0] prod_y1;
    logic signed [PROD_BITS-1:0] prod_y2;
    logic signed [PROD_BITS-1:0] prod_u0;
    logic signed [PROD_BITS-1:0] prod_u1;
    logic signed [PROD_BITS-1:0] prod_u2;
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [SH_BITS-1:0]   rounded;

    always_comb begin
        prod_y1 = PROD_BITS'(fb_coef_one)  * PROD_BITS'(output_delay_one);
        prod_y2 = PROD_BITS'(fb_coef_two)  * PROD_BITS'(output_delay_two);
        prod_u0 = PROD_BITS'(ff_coef_zero) * PROD_BITS'(sample);
        prod_u1 = PROD_BITS'(ff_coef_one)  * PROD_BITS'(input_delay_one);
        prod_u2 = PROD_BITS'(ff_coef_two)  * PROD_BITS'(input_delay_two);
        acc = ACC_BITS'(prod_y1) + ACC_BITS'(prod_y2) + ACC_BITS'(prod_u0)
            + ACC_BITS'(prod_u1) + ACC_BITS'(prod_u2) + HALF_LSB;
        rounded = acc[ACC_BITS-1:COEF_FRAC_BITS];
        if (rounded > SAT_MAX) begin
            result = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (rounded < SAT_MIN) begin
            result = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            result = rounded[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ----- design/biquad_checker.sv -----
// port-level assertions for the biquad filter and their binding
module biquad_checker
    import biquad_pkg::*;
#(
    parameter int TDATA_BITS = 24
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_BITS-1:0] m_tdata,
    input logic                  cfg_ready
);

    // a result waiting for transfer holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // input only backs up when the output side is full and stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // a stalled input transfer keeps the stage busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tvalid && !m_tready |=> m_tvalid && (s_tready == m_tready))
        else $error("accepted sample lost under backpressure");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind second_order_iir_filter biquad_checker #(
    .TDATA_BITS (TDATA_BITS)
) u_biquad_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

// ----- sim/testbench.sv -----
// self-checking testbench for the direct form i biquad filter with its own fixed-point predictor
module testbench;
    import biquad_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
    localparam int COEF_W    = COEF_BITS_DEF;
    localparam int FRAC_W    = COEF_FRAC_BITS_DEF;
    localparam int DATA_W    = ((SAMPLE_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

    localparam logic [SAMPLE_W-1:0] SMP_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SMP_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [SAMPLE_W-1:0] SMP_ONES = {SAMPLE_W{1'b1}};
    localparam logic [SAMPLE_W-1:0] SMP_ALT5 = {(SAMPLE_W/2){2'b01}};
    localparam logic [SAMPLE_W-1:0] SMP_ALTA = {(SAMPLE_W/2){2'b10}};

    localparam logic signed [COEF_W-1:0] Q_ONE  = COEF_W'(longint'(1) <<< FRAC_W);
    localparam logic signed [COEF_W-1:0] Q_HALF = COEF_W'(longint'(1) <<< (FRAC_W - 1));
    localparam logic signed [COEF_W-1:0] Q_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] Q_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] Q_LSB  = COEF_W'(1);

    localparam logic [CFG_INDEX_BITS-1:0] COEF_REGS [5] = '{
        REG_FB_COEF_ONE, REG_FB_COEF_TWO, REG_FF_COEF_ZERO, REG_FF_COEF_ONE, REG_FF_COEF_TWO
    };
    localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_INDEX = {CFG_INDEX_BITS{1'b1}};

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [DATA_W-1:0]         s_tdata = '0;    // sample_in
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [DATA_W-1:0]         m_tdata;         // sample_out
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [COEF_W-1:0]         cfg_data = '0;

    // predictor copy of the coefficients and the filter history
    logic signed [COEF_W-1:0]   coef_a1 = '0, coef_a2 = '0;
    logic signed [COEF_W-1:0]   coef_b0 = '0, coef_b1 = '0, coef_b2 = '0;
    logic signed [SAMPLE_W-1:0] in_d1 = '0, in_d2 = '0, out_d1 = '0, out_d2 = '0;

    logic [DATA_W-1:0] expected_samples [$];
    logic [DATA_W-1:0] want_sample;
    int error_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    second_order_iir_filter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [SAMPLE_W-1:0] biquad_response(input logic signed [SAMPLE_W-1:0] u);
        longint acc;
        logic signed [SAMPLE_W-1:0] y;
        acc = longint'(coef_a1) * longint'(out_d1) + longint'(coef_a2) * longint'(out_d2)
            + longint'(coef_b0) * longint'(u) + longint'(coef_b1) * longint'(in_d1)
            + longint'(coef_b2) * longint'(in_d2);
        acc = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (acc > SAMPLE_MAX) begin
            y = SMP_MAX;
        end else if (acc < SAMPLE_MIN) begin
            y = SMP_MIN;
        end else begin
            y = acc[SAMPLE_W-1:0];
        end
        out_d2 = out_d1;
        out_d1 = y;
        in_d2 = in_d1;
        in_d1 = u;
        return y;
    endfunction

    function automatic void store_coef(input logic [CFG_INDEX_BITS-1:0] idx,
                                       input logic [COEF_W-1:0] data);
        case (idx)
            REG_FB_COEF_ONE:  coef_a1 = data;
            REG_FB_COEF_TWO:  coef_a2 = data;
            REG_FF_COEF_ZERO: coef_b0 = data;
            REG_FF_COEF_ONE:  coef_b1 = data;
            REG_FF_COEF_TWO:  coef_b2 = data;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] u);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(u);
        do @(posedge aclk); while (!s_tready);
        expected_samples.push_back(DATA_W'(biquad_response(u)));
    endtask

    task automatic cfg_transfer(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        store_coef(idx, data);
    endtask

    // drain the pipeline, then write all five coefficients and one unused index
    task automatic program_coefs(input logic signed [COEF_W-1:0] a1, a2, b0, b1, b2);
        logic [COEF_W-1:0] vals [5];
        vals = '{a1, a2, b0, b1, b2};
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        for (int i = 0; i < 5; i++) cfg_transfer(COEF_REGS[i], vals[i]);
        cfg_transfer(CFG_INDEX_BITS'($urandom_range(REG_FF_COEF_TWO + 1, REG_LAST_INDEX)),
                     $urandom);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(19))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return '0;
            3: return SMP_ONES;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef(input int style, input int slot);
        case (style)
            0: return $urandom;
            1: return $signed($urandom) >>> 2;
            default: begin
                if (slot == 0) return $urandom_range(32'h7000_0000, 32'h4000_0000);
                if (slot == 1) return -$signed($urandom_range(32'h3C00_0000, 32'h2000_0000));
                return $signed($urandom) >>> 4;
            end
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(SMP_ALT5);
    endtask

    task automatic test_passthrough();
        program_coefs('0, '0, Q_ONE, '0, '0);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample('0);
        send_sample(SMP_ONES);
        send_sample(SAMPLE_W'(1));
        send_sample(SMP_ALT5);
        send_sample(SMP_ALTA);
    endtask

    // half-lsb ties round toward plus infinity
    task automatic test_rounding_ties();
        program_coefs('0, '0, Q_HALF, '0, '0);
        send_sample(SAMPLE_W'(1));
        send_sample(SMP_ONES);
        send_sample(SAMPLE_W'(3));
        send_sample(SAMPLE_W'(-3));
        program_coefs('0, '0, Q_LSB, '0, '0);
        send_sample(SMP_MAX);
    endtask

    task automatic test_saturation();
        program_coefs('0, '0, Q_MAX, '0, '0);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        program_coefs('0, '0, Q_MIN, '0, '0);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
    endtask

    // saturated output fed back, then pure history taps
    task automatic test_history_terms();
        program_coefs(Q_MAX, '0, Q_ONE, '0, '0);
        send_sample(SMP_MAX);
        send_sample('0);
        send_sample('0);
        program_coefs('0, -Q_HALF, '0, Q_ONE, -Q_ONE);
        send_sample(SAMPLE_W'(1000));
        send_sample(SAMPLE_W'(-77));
        send_sample(SMP_MIN);
    endtask

    task automatic test_random_filters();
        int idle_tab [4];
        int stall_tab [4];
        logic signed [COEF_W-1:0] c [5];
        idle_tab  = '{0, 65, 0, 23};
        stall_tab = '{0, 0, 65, 23};
        for (int s = 0; s < 8; s++) begin
            for (int k = 0; k < 5; k++) begin
                if (s == 0) c[k] = Q_MAX;
                else if (s == 1) c[k] = Q_MIN;
                else c[k] = rand_coef(s % 3, k);
            end
            program_coefs(c[0], c[1], c[2], c[3], c[4]);
            idle_pct  = idle_tab[s % 4];
            stall_pct = stall_tab[s % 4];
            for (int n = 0; n < 88; n++) send_sample(rand_sample());
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("sample_out with none pending", m_tdata, '0);
            end else begin
                want_sample = expected_samples.pop_front();
                if (m_tdata !== want_sample) report_mismatch("sample_out", m_tdata, want_sample);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_passthrough();
        test_rounding_ties();
        test_saturation();
        test_history_terms();
        test_random_filters();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
